// ===== hw/rtl/hkvm_pkg.sv =====
// ----------------------------------------------------------------------------
// hkvm_pkg: shared types and constants of the hashed key-value map
// Sizing of the bucket table, the action codes and the packed words that
// travel on the input and output channels and through the bucket memory.
// ----------------------------------------------------------------------------
package hkvm_pkg;

  // Number of buckets. It must be a power of two, so that the bucket of a key
  // is simply its low bits.
  localparam int unsigned BUCKETS  = 256;
  // Ways (entries) per bucket.
  localparam int unsigned WAYS     = 4;

  localparam int unsigned KEY_W    = 64;
  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned BUCKET_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  // The fill count runs from zero up to WAYS inclusive.
  localparam int unsigned FILL_W   = $clog2(WAYS + 1);

  typedef enum logic [1:0] {
    ActLookup = 2'd0,
    ActInsert = 2'd1,
    ActClear  = 2'd2,
    ActNone   = 2'd3
  } action_e;

  typedef struct packed {
    logic [1:0]         action;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic               found;
    logic [VALUE_W-1:0] result_value;
    logic               status;
  } out_word_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } entry_t;

  // One memory row holds a whole bucket: its fill count and all of its ways.
  typedef struct packed {
    logic [FILL_W-1:0]   fill;
    entry_t [WAYS-1:0]   ways;
  } row_t;

  localparam int unsigned ROW_W = $bits(row_t);

endpackage

// ===== hw/rtl/hkvm_ram.sv =====
// ----------------------------------------------------------------------------
// hkvm_ram: generic single-clock RAM
// One write port and one read port; the read data is registered, so it
// appears in the cycle after the read enable and holds until the next read.
// ----------------------------------------------------------------------------
module hkvm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [$clog2(Depth)-1:0]          waddr_i,
  input  logic [Width-1:0]                  wdata_i,
  input  logic                              re_i,
  input  logic [$clog2(Depth)-1:0]          raddr_i,
  output logic [Width-1:0]                  rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/hashed_key_value_map.sv =====
// Timing: when a word is accepted, its bucket row is read; the result word is
// registered once the output register can take it, so an output stall holds
// the word in flight. A new word is not taken before the last one is through,
// so the read and any write-back of a bucket row in the single memory never overlap.
// Reset clears the control state and all bucket valid bits at once, so every
// bucket is empty right after reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
// hashed_key_value_map: bucketed associative map from 64-bit keys to values
// Each bucket is one row of a memory holding its fill count and its ways.
// Lookups return the newest matching way, inserts append to the bucket.
// ----------------------------------------------------------------------------
module hashed_key_value_map (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  hkvm_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output hkvm_pkg::out_word_t out_data_o
);
  import hkvm_pkg::*;

  // The design is a two-step sequencer around the bucket memory. In the
  // first step the word is taken and the row of its bucket is read. In the
  // second step the row is compared, and once the output register is free an
  // insert writes the modified row back and the answer goes into the output
  // register. A new word is only taken once the previous one has written back,
  // so reads never overlap a write to the same row and no forwarding is needed.

  logic                busy_q;
  in_word_t            item_q;
  logic                row_valid_q;
  logic [BUCKETS-1:0]  valid_q, valid_d;
  logic                out_valid_q;
  out_word_t           out_data_q;

  logic                accept;
  logic                complete;
  logic [BUCKET_W-1:0] in_bucket;
  logic [BUCKET_W-1:0] item_bucket;
  logic [ROW_W-1:0]    rdata;
  row_t                row;
  row_t                new_row;
  logic [FILL_W-1:0]   fill_eff;
  logic                full;
  logic                ram_we;
  out_word_t           result;

  // A word is taken only while no other word is in flight.
  assign in_stall_o = busy_q;
  assign accept     = in_valid_i & ~busy_q;

  // The in-flight word finishes when the output register can take its answer.
  assign complete   = busy_q & (~out_valid_q | ~out_stall_i);

  assign in_bucket   = in_data_i.key[BUCKET_W-1:0];
  assign item_bucket = item_q.key[BUCKET_W-1:0];

  hkvm_ram #(
    .Width (ROW_W),
    .Depth (BUCKETS)
  ) u_bucket_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (item_bucket),
    .wdata_i (new_row),
    .re_i    (accept),
    .raddr_i (in_bucket),
    .rdata_o (rdata)
  );

  assign row = row_t'(rdata);

  // A bucket whose valid bit is clear is empty, whatever the row holds.
  assign fill_eff = row_valid_q ? row.fill : '0;
  assign full     = (fill_eff >= FILL_W'(WAYS));

  always_comb begin
    result         = '0;
    new_row        = row;
    new_row.fill   = fill_eff + FILL_W'(1);
    unique case (action_e'(item_q.action))
      ActLookup: begin
        // Later ways are newer, so the highest filled match wins.
        for (int w = 0; w < WAYS; w++) begin
          if ((FILL_W'(w) < fill_eff) && (row.ways[w].key == item_q.key)) begin
            result.found        = 1'b1;
            result.result_value = row.ways[w].value;
          end
        end
      end
      ActInsert: begin
        result.status = full;
        for (int w = 0; w < WAYS; w++) begin
          if (FILL_W'(w) == fill_eff) begin
            new_row.ways[w].key   = item_q.key;
            new_row.ways[w].value = item_q.value;
          end
        end
      end
      ActClear: begin
        result = '0;
      end
      default: begin
        result = '0;
      end
    endcase
  end

  assign ram_we = complete & (action_e'(item_q.action) == ActInsert) & ~full;

  always_comb begin
    valid_d = valid_q;
    if (complete && (action_e'(item_q.action) == ActClear)) begin
      valid_d = '0;
    end else if (ram_we) begin
      valid_d[item_bucket] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (complete) begin
        busy_q <= 1'b0;
      end
      if (complete) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q      <= in_data_i;
      row_valid_q <= valid_q[in_bucket];
    end
    if (complete) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== hw/rtl/hkvm_checker.sv =====
// ----------------------------------------------------------------------------
// hkvm_checker: port-level checks of the hashed key-value map
// Watches the two channels and flags ordering and result-field errors.
// ----------------------------------------------------------------------------
module hkvm_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_o,
  input  hkvm_pkg::in_word_t  in_data_i,
  input  logic               out_valid_o,
  input  logic               out_stall_i,
  input  hkvm_pkg::out_word_t out_data_o
);
  import hkvm_pkg::*;

  // After taking a word the block is busy for the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken in the cycle after an accepted word");

  // A new answer only appears once a word has been in flight.
  a_answer_needs_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("answer without a word in flight");

  // A word never reports a hit and a dropped insert at once.
  a_found_or_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.found && out_data_o.status))
    else $error("found and status both set");

  // A stalled answer stays in place.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled answer changed");

  // A stalled input word stays offered and unchanged.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=> (in_valid_i && $stable(in_data_i)))
    else $error("stalled input word changed");

endmodule

bind hashed_key_value_map hkvm_checker u_hkvm_checker (.*);

// ===== tb/sv/tb_hashed_key_value_map.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hashed_key_value_map: self-checking bench for the hashed key-value map
// Drives lookup, insert, clear and unused-code words through the valid/stall input channel
// and compares every output word against a cycle-free predictor of the table.
// Three phases vary the idling on both sides, and one phase forces backpressure.
// ----------------------------------------------------------------------------
module tb_hashed_key_value_map;
  import hkvm_pkg::*;

  // --------------------------------------------------------------------------
  // Scoreboard: it keeps its own copy of the bucket table, works out the
  // answer for every accepted input word, and holds the answers in order
  // until the block delivers its output words.
  // --------------------------------------------------------------------------
  class map_scoreboard;
    logic [KEY_W-1:0]   way_key   [BUCKETS*WAYS];
    logic [VALUE_W-1:0] way_value [BUCKETS*WAYS];
    int unsigned        fill      [BUCKETS];
    out_word_t          answers_q [$];
    int unsigned        errors;

    function new();
      foreach (fill[i]) fill[i] = 0;
      errors = 0;
    endfunction

    // Update the table for one accepted word and queue the answer it implies.
    function void note_input(in_word_t w);
      out_word_t   r;
      int unsigned b;
      int unsigned slot;
      r = '0;
      b = w.key % BUCKETS;
      case (action_e'(w.action))
        ActLookup: begin
          // The newest way is searched first, so a duplicate key answers
          // with the value that was inserted last.
          for (int i = fill[b]; i > 0 && !r.found; i--) begin
            slot = b * WAYS + i - 1;
            if (way_key[slot] == w.key) begin
              r.found        = 1'b1;
              r.result_value = way_value[slot];
            end
          end
        end
        ActInsert: begin
          if (fill[b] >= WAYS) begin
            r.status = 1'b1;
          end else begin
            slot            = b * WAYS + fill[b];
            way_key[slot]   = w.key;
            way_value[slot] = w.value;
            fill[b]++;
          end
        end
        ActClear: begin
          foreach (fill[i]) fill[i] = 0;
        end
        default: begin
        end
      endcase
      answers_q.push_back(r);
    endfunction

    // Compare one output word with the oldest answer still waiting.
    function void check_result(out_word_t got);
      out_word_t want;
      if (answers_q.size() == 0) begin
        errors++;
        $error("output word with no answer waiting: %h", got);
        return;
      end
      want = answers_q.pop_front();
      if (got.found !== want.found) begin
        errors++;
        $error("found: expected %0d, actual %0d", want.found, got.found);
      end
      if (got.result_value !== want.result_value) begin
        errors++;
        $error("result_value: expected %h, actual %h", want.result_value,
               got.result_value);
      end
      if (got.status !== want.status) begin
        errors++;
        $error("status: expected %0d, actual %0d", want.status, got.status);
      end
    endfunction

    function int unsigned pending();
      return answers_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and the device under test.
  // --------------------------------------------------------------------------
  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_data;

  hashed_key_value_map uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  map_scoreboard sb = new();

  // Idling odds in percent for both sides, changed from phase to phase.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  // A request for one long receiver hold-off; the receiver counts it down.
  bit          hold_req      = 1'b0;

  // Keys inserted recently, so that lookups and duplicate inserts hit them.
  logic [KEY_W-1:0] stored_keys [$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // A fixed upper bound on the run: far above the slowest correct run.
  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: the output channel is sampled at the falling edge, where all of
  // the block's outputs have settled, and the word counts as taken at the
  // rising edge that follows. The stall for the next cycle is set right after.
  // --------------------------------------------------------------------------
  initial begin
    bit          took;
    out_word_t   got;
    int unsigned hold_cnt;
    hold_cnt = 0;
    forever begin
      @(negedge clk);
      took = out_valid && !out_stall;
      got  = out_data;
      @(posedge clk);
      if (took) sb.check_result(got);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 150;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender: offer one word, possibly after a few idle cycles, and hold it
  // steady until the block takes it. Called and returning at a rising edge.
  // --------------------------------------------------------------------------
  task automatic send_word(input in_word_t w);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    sb.note_input(w);
    if (action_e'(w.action) == ActInsert) begin
      stored_keys.push_back(w.key);
      if (stored_keys.size() > 32) void'(stored_keys.pop_front());
    end
  endtask

  // Stop offering and wait until every answer has been delivered.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic in_word_t make_word(action_e a, logic [KEY_W-1:0] k,
                                         logic [VALUE_W-1:0] v);
    in_word_t w;
    w.action = a;
    w.key    = k;
    w.value  = v;
    return w;
  endfunction

  // A random key that lands in one of a few crowded buckets, so that buckets
  // fill up and inserts get dropped; the upper bits stay random.
  function automatic logic [KEY_W-1:0] crowded_key();
    logic [KEY_W-1:0] k;
    int unsigned      pick;
    k    = {$urandom, $urandom};
    pick = $urandom_range(3);
    k    = k - (k % BUCKETS) + ((pick == 3) ? BUCKETS - 1 : pick);
    return k;
  endfunction

  // One random word: mostly inserts and lookups on keys that share buckets or
  // were stored before, with a few clears, unused action codes and wild keys.
  function automatic in_word_t random_word();
    int unsigned      r;
    int unsigned      k;
    action_e          a;
    logic [KEY_W-1:0] key;
    r = $urandom_range(99);
    k = $urandom_range(99);
    if (r < 1)       a = ActClear;
    else if (r < 3)  a = ActNone;
    else if (r < 52) a = ActInsert;
    else             a = ActLookup;
    if (a == ActLookup && k < 60 && stored_keys.size() > 0)
      key = stored_keys[$urandom_range(stored_keys.size() - 1)];
    else if (a == ActInsert && k < 15 && stored_keys.size() > 0)
      key = stored_keys[$urandom_range(stored_keys.size() - 1)];
    else if (k < 80)
      key = crowded_key();
    else
      key = {$urandom, $urandom};
    return make_word(a, key, {$urandom, $urandom});
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    in_word_t directed_q [$];

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: empty table, extreme keys and values, a full bucket
    // with a dropped insert, a duplicate key, the unused action code, and
    // a clear followed by lookups and inserts.
    directed_q.push_back(make_word(ActLookup, '0, '1));
    directed_q.push_back(make_word(ActInsert, '0, '1));
    directed_q.push_back(make_word(ActInsert, '1, '0));
    directed_q.push_back(make_word(ActLookup, '0, '0));
    directed_q.push_back(make_word(ActLookup, '1, '0));
    directed_q.push_back(make_word(ActInsert, 64'h5, 64'h1111_0000_0000_0005));
    directed_q.push_back(make_word(ActInsert, 64'h105, 64'h2222_0000_0000_0105));
    directed_q.push_back(make_word(ActInsert, 64'h205, 64'h3333_0000_0000_0205));
    directed_q.push_back(make_word(ActInsert, 64'h305, 64'h4444_0000_0000_0305));
    // Bucket five is full now: this insert is dropped.
    directed_q.push_back(make_word(ActInsert, 64'h405, 64'h5555_0000_0000_0405));
    directed_q.push_back(make_word(ActLookup, 64'h405, '0));
    directed_q.push_back(make_word(ActLookup, 64'h105, '0));
    directed_q.push_back(make_word(ActLookup, 64'hFFFF_FFFF_FFFF_FF05, '0));
    // Same key twice: the lookup must return the second value.
    directed_q.push_back(make_word(ActInsert, 64'h8000_0000_0000_0007,
                                   64'hAAAA_AAAA_AAAA_AAAA));
    directed_q.push_back(make_word(ActInsert, 64'h8000_0000_0000_0007,
                                   64'h5555_5555_5555_5555));
    directed_q.push_back(make_word(ActLookup, 64'h8000_0000_0000_0007, '0));
    directed_q.push_back(make_word(ActLookup, 64'h7, '0));
    // The unused action code must leave the table alone.
    directed_q.push_back(make_word(ActNone, '1, '1));
    directed_q.push_back(make_word(ActLookup, '0, '0));
    directed_q.push_back(make_word(ActClear, '1, '1));
    directed_q.push_back(make_word(ActLookup, '0, '0));
    directed_q.push_back(make_word(ActLookup, 64'h105, '0));
    directed_q.push_back(make_word(ActInsert, 64'h405, 64'h0123_4567_89AB_CDEF));
    directed_q.push_back(make_word(ActLookup, 64'h405, '0));
    foreach (directed_q[i]) send_word(directed_q[i]);
    drain();

    // Phase one: the sender idles now and then, the receiver often.
    send_idle_pct = 27;
    recv_idle_pct = 69;
    repeat (270) send_word(random_word());
    drain();

    // Phase two: the other way round.
    send_idle_pct = 69;
    recv_idle_pct = 27;
    repeat (270) send_word(random_word());
    drain();

    // Phase three: no idling, and the receiver starts with a long hold-off
    // while words keep coming, so the block fills up and stalls its input.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 1'b1;
    repeat (260) send_word(random_word());
    drain();

    // Leave room for any stray output word to show up.
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/hkvm_pkg.sv
hw/rtl/hkvm_ram.sv
hw/rtl/hashed_key_value_map.sv
hw/rtl/hkvm_checker.sv
tb/sv/tb_hashed_key_value_map.sv
